// ===== src/sle_pkg.sv =====
// ----------------------------------------------------------------------------
// Sorted list engine package
// Shared constants, codes and interface types for the sorted list engine.
// ----------------------------------------------------------------------------
package sle_pkg;

    localparam int CAPACITY = 32;
    localparam int DATA_W   = 32;
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;

    localparam logic [1:0] OP_INSERT    = 2'd0;
    localparam logic [1:0] OP_DELETE    = 2'd1;
    localparam logic [1:0] OP_READ_ASC  = 2'd2;
    localparam logic [1:0] OP_READ_DESC = 2'd3;

    localparam logic [2:0] ST_INSERTED  = 3'd0;
    localparam logic [2:0] ST_REMOVED   = 3'd1;
    localparam logic [2:0] ST_NOT_FOUND = 3'd2;
    localparam logic [2:0] ST_FULL      = 3'd3;
    localparam logic [2:0] ST_ENTRY     = 3'd4;
    localparam logic [2:0] ST_EMPTY     = 3'd5;

    typedef enum logic {
        S_IDLE,
        S_READ
    } t_state;

    typedef struct packed {
        logic             ins;
        logic             del;
        logic             emit_empty;
        logic             emit_entry;
        logic             rd_last;
        logic [IDX_W-1:0] rd_idx;
    } t_dp_cmd;

    typedef struct packed {
        logic [CNT_W-1:0] count;
    } t_dp_stat;

endpackage

// ===== src/sle_ctrl.sv =====
// ----------------------------------------------------------------------------
// Sorted list engine controller
// Accepts items, issues insert and delete commands and sequences list reads.
// ----------------------------------------------------------------------------
module sle_ctrl
    import sle_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       start,
    output logic       busy,
    input  logic [1:0] i_opcode,
    input  t_dp_stat   i_stat,
    output t_dp_cmd    o_cmd
);

    t_state           r_state;
    t_state           n_state;
    logic [CNT_W-1:0] r_k;
    logic [CNT_W-1:0] n_k;
    logic             r_desc;
    logic             n_desc;
    logic [CNT_W-1:0] w_desc_idx;
    logic [CNT_W-1:0] w_k_inc;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_k     <= '0;
            r_desc  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_k     <= n_k;
            r_desc  <= n_desc;
        end
    end

    assign w_desc_idx = i_stat.count - r_k - CNT_W'(1);
    assign w_k_inc    = r_k + CNT_W'(1);

    always_comb begin
        n_state = r_state;
        n_k     = r_k;
        n_desc  = r_desc;
        busy    = 1'b0;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (start) begin
                    case (i_opcode)
                        OP_INSERT: begin
                            o_cmd.ins = 1'b1;
                        end
                        OP_DELETE: begin
                            o_cmd.del = 1'b1;
                        end
                        default: begin
                            if (i_stat.count == '0) begin
                                o_cmd.emit_empty = 1'b1;
                            end else begin
                                n_state = S_READ;
                                n_k     = '0;
                                n_desc  = (i_opcode == OP_READ_DESC);
                            end
                        end
                    endcase
                end
            end
            S_READ: begin
                busy             = 1'b1;
                o_cmd.emit_entry = 1'b1;
                o_cmd.rd_idx     = r_desc ? w_desc_idx[IDX_W-1:0] : r_k[IDX_W-1:0];
                o_cmd.rd_last    = (w_k_inc == i_stat.count);
                n_k              = w_k_inc;
                if (o_cmd.rd_last) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

// ===== src/sle_datapath.sv =====
// ----------------------------------------------------------------------------
// Sorted list engine datapath
// Row of compare-and-shift cells holding the sorted list, plus result registers.
// ----------------------------------------------------------------------------
module sle_datapath
    import sle_pkg::*;
(
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  t_dp_cmd                  i_cmd,
    input  logic signed [DATA_W-1:0] i_value,
    output t_dp_stat                 o_stat,
    output logic                     o_valid,
    output logic signed [DATA_W-1:0] o_result_value,
    output logic [2:0]               o_status,
    output logic                     o_last
);

    logic signed [DATA_W-1:0] r_entries [CAPACITY];
    logic signed [DATA_W-1:0] n_entries [CAPACITY];
    logic signed [DATA_W-1:0] w_prev    [CAPACITY];
    logic signed [DATA_W-1:0] w_next    [CAPACITY];
    logic [CAPACITY-1:0]      w_after;
    logic [CAPACITY-1:0]      w_after_prev;
    logic [CAPACITY-1:0]      w_eq;
    logic [CAPACITY-1:0]      w_hit;
    logic [CNT_W-1:0]         r_count;
    logic [CNT_W-1:0]         n_count;
    logic                     w_full;
    logic                     w_found;
    logic                     r_valid;
    logic signed [DATA_W-1:0] r_result_value;
    logic [2:0]               r_status;
    logic                     r_last;
    logic                     n_valid;
    logic signed [DATA_W-1:0] n_result_value;
    logic [2:0]               n_status;
    logic                     n_last;

    // Each cell compares its entry against the item value on its own.
    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        assign w_after[g] = (CNT_W'(g) >= r_count) || !(r_entries[g] < i_value);
        assign w_eq[g]    = (CNT_W'(g) < r_count) && (r_entries[g] == i_value);
        if (g == 0) begin : g_first
            assign w_prev[g]       = i_value;
            assign w_after_prev[g] = 1'b0;
            assign w_hit[g]        = w_eq[g];
        end else begin : g_rest
            assign w_prev[g]       = r_entries[g-1];
            assign w_after_prev[g] = w_after[g-1];
            assign w_hit[g]        = w_hit[g-1] | w_eq[g];
        end
        if (g == CAPACITY - 1) begin : g_end
            assign w_next[g] = r_entries[g];
        end else begin : g_mid
            assign w_next[g] = r_entries[g+1];
        end
    end

    assign w_full  = (r_count == CNT_W'(CAPACITY));
    assign w_found = w_hit[CAPACITY-1];

    always_comb begin
        n_count = r_count;
        for (int i = 0; i < CAPACITY; i++) begin
            n_entries[i] = r_entries[i];
            if (i_cmd.ins && !w_full && w_after[i]) begin
                n_entries[i] = w_after_prev[i] ? w_prev[i] : i_value;
            end else if (i_cmd.del && w_hit[i]) begin
                n_entries[i] = w_next[i];
            end
        end
        if (i_cmd.ins && !w_full) begin
            n_count = r_count + CNT_W'(1);
        end else if (i_cmd.del && w_found) begin
            n_count = r_count - CNT_W'(1);
        end
    end

    always_comb begin
        n_valid        = 1'b0;
        n_result_value = i_value;
        n_status       = ST_INSERTED;
        n_last         = 1'b1;
        if (i_cmd.ins) begin
            n_valid  = 1'b1;
            n_status = w_full ? ST_FULL : ST_INSERTED;
        end else if (i_cmd.del) begin
            n_valid  = 1'b1;
            n_status = w_found ? ST_REMOVED : ST_NOT_FOUND;
        end else if (i_cmd.emit_empty) begin
            n_valid        = 1'b1;
            n_result_value = '0;
            n_status       = ST_EMPTY;
        end else if (i_cmd.emit_entry) begin
            n_valid        = 1'b1;
            n_result_value = r_entries[i_cmd.rd_idx];
            n_status       = ST_ENTRY;
            n_last         = i_cmd.rd_last;
        end
    end

    always_ff @(posedge i_clk) begin
        for (int i = 0; i < CAPACITY; i++) begin
            r_entries[i] <= n_entries[i];
        end
        r_result_value <= n_result_value;
        r_status       <= n_status;
        r_last         <= n_last;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_valid <= 1'b0;
        end else begin
            r_count <= n_count;
            r_valid <= n_valid;
        end
    end

    assign o_stat.count   = r_count;
    assign o_valid        = r_valid;
    assign o_result_value = r_result_value;
    assign o_status       = r_status;
    assign o_last         = r_last;

endmodule

// ===== src/sorted_list_engine_unit.sv =====
// ----------------------------------------------------------------------------
// Sorted list engine
// Bounded list of signed values kept in ascending order, with insert, delete
// and ascending or descending read-out.
// ----------------------------------------------------------------------------
// An item is taken when start is high and busy is low. Insert and delete
// may follow one another on every cycle; their single result appears on the
// cycle after the item is taken. A read of a list holding n entries keeps
// busy high until the controller has selected all n entries, selecting one
// entry per cycle because the cell row has one read port; the entries appear
// one per cycle, each registered in the datapath after the controller has
// entered its read state. A read of an empty list gives one result on the
// cycle after the item is taken. Every result is shown for exactly one cycle
// with o_valid high and cannot be held off, so the receiver must take it on
// that cycle.
module sorted_list_engine_unit
    import sle_pkg::*;
(
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     start,
    output logic                     busy,
    input  logic [1:0]               i_opcode,
    input  logic signed [DATA_W-1:0] i_value,
    output logic                     o_valid,
    output logic signed [DATA_W-1:0] o_result_value,
    output logic [2:0]               o_status,
    output logic                     o_last
);

    t_dp_cmd  w_cmd;
    t_dp_stat w_stat;

    sle_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .busy     (busy),
        .i_opcode (i_opcode),
        .i_stat   (w_stat),
        .o_cmd    (w_cmd)
    );

    sle_datapath u_datapath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (w_cmd),
        .i_value        (i_value),
        .o_stat         (w_stat),
        .o_valid        (o_valid),
        .o_result_value (o_result_value),
        .o_status       (o_status),
        .o_last         (o_last)
    );

    a_ins_del_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy && (i_opcode == OP_INSERT || i_opcode == OP_DELETE)
        |=> o_valid && o_last)
        else $error("Insert or delete item gave no single final result.");

    a_read_streams: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        busy |=> o_valid && o_status == ST_ENTRY)
        else $error("Read sequencing cycle gave no entry result.");

    a_read_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_status == ST_ENTRY && o_last |-> !busy)
        else $error("Engine still busy after the last entry of a read.");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_stat.count <= CNT_W'(CAPACITY))
        else $error("List count exceeds capacity.");

endmodule

// ===== sim/sorted_list_checker.sv =====
// ----------------------------------------------------------------------------
// Sorted list engine checker
// Watches the command and result ports of the sorted list engine, keeps its
// own sorted list and checks each result, in order, field by field.
// ----------------------------------------------------------------------------
module sorted_list_checker
    import sle_pkg::*;
(
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     start,
    input  logic                     busy,
    input  logic [1:0]               i_opcode,
    input  logic signed [DATA_W-1:0] i_value,
    input  logic                     i_valid,
    input  logic signed [DATA_W-1:0] i_result_value,
    input  logic [2:0]               i_status,
    input  logic                     i_last,
    output int                       o_fail_count,
    output int                       o_pending
);

    typedef struct packed {
        logic [DATA_W-1:0] value;
        logic [2:0]        status;
        logic              last;
    } t_result;

    t_result                  due_results[$];
    logic signed [DATA_W-1:0] sorted_vals[CAPACITY];
    int                       n_held;
    int                       fails;

    function automatic t_result make_result(input logic [DATA_W-1:0] v,
                                            input logic [2:0] st, input logic lst);
        t_result r;
        r.value  = v;
        r.status = st;
        r.last   = lst;
        return r;
    endfunction

    task automatic apply_op(input logic [1:0] op, input logic signed [DATA_W-1:0] v);
        int pos;
        int i;
        int idx;
        case (op)
            OP_INSERT: begin
                if (n_held >= CAPACITY) begin
                    due_results.push_back(make_result(v, ST_FULL, 1'b1));
                end else begin
                    pos = 0;
                    while (pos < n_held && sorted_vals[pos] < v) pos++;
                    for (i = n_held; i > pos; i--) sorted_vals[i] = sorted_vals[i-1];
                    sorted_vals[pos] = v;
                    n_held++;
                    due_results.push_back(make_result(v, ST_INSERTED, 1'b1));
                end
            end
            OP_DELETE: begin
                pos = 0;
                while (pos < n_held && sorted_vals[pos] != v) pos++;
                if (pos >= n_held) begin
                    due_results.push_back(make_result(v, ST_NOT_FOUND, 1'b1));
                end else begin
                    for (i = pos; i + 1 < n_held; i++) sorted_vals[i] = sorted_vals[i+1];
                    n_held--;
                    due_results.push_back(make_result(v, ST_REMOVED, 1'b1));
                end
            end
            default: begin
                if (n_held == 0) begin
                    due_results.push_back(make_result('0, ST_EMPTY, 1'b1));
                end else begin
                    for (i = 0; i < n_held; i++) begin
                        idx = (op == OP_READ_ASC) ? i : n_held - 1 - i;
                        due_results.push_back(make_result(sorted_vals[idx], ST_ENTRY,
                                                          i + 1 == n_held));
                    end
                end
            end
        endcase
    endtask

    always @(posedge i_clk) begin
        t_result r;
        if (!i_rst_n) begin
            n_held = 0;
            due_results.delete();
        end else begin
            if (i_valid === 1'b1) begin
                if (due_results.size() == 0) begin
                    fails++;
                    $display("%0t: result expected none, actual value %0d status %0d last %0d",
                             $time, i_result_value, i_status, i_last);
                end else begin
                    r = due_results.pop_front();
                    if (r.value !== i_result_value) begin
                        fails++;
                        $display("%0t: result_value expected %0d, actual %0d",
                                 $time, $signed(r.value), i_result_value);
                    end
                    if (r.status !== i_status) begin
                        fails++;
                        $display("%0t: status expected %0d, actual %0d",
                                 $time, r.status, i_status);
                    end
                    if (r.last !== i_last) begin
                        fails++;
                        $display("%0t: last expected %0d, actual %0d", $time, r.last, i_last);
                    end
                end
            end else if (i_valid !== 1'b0) begin
                fails++;
                $display("%0t: o_valid expected 0 or 1, actual %b", $time, i_valid);
            end
            if (start && !busy) apply_op(i_opcode, i_value);
        end
        o_fail_count <= fails;
        o_pending    <= due_results.size();
    end

endmodule

// ===== sim/sorted_list_engine_unit_test.sv =====
// ----------------------------------------------------------------------------
// Sorted list engine testbench
// Drives directed and random inserts, deletes and reads into the sorted list
// engine with random idle gaps, and reports the verdict of the checker.
// ----------------------------------------------------------------------------
module sorted_list_engine_unit_test;
    import sle_pkg::*;

    logic                     i_clk;
    logic                     i_rst_n;
    logic                     start;
    logic                     busy;
    logic [1:0]               i_opcode;
    logic signed [DATA_W-1:0] i_value;
    logic                     o_valid;
    logic signed [DATA_W-1:0] o_result_value;
    logic [2:0]               o_status;
    logic                     o_last;
    int                       fail_count;
    int                       pending;

    logic signed [DATA_W-1:0] held[$];
    logic                     burst;

    localparam logic signed [DATA_W-1:0] VAL_MIN = 32'sh8000_0000;
    localparam logic signed [DATA_W-1:0] VAL_MAX = 32'sh7fff_ffff;

    sorted_list_engine_unit dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_opcode       (i_opcode),
        .i_value        (i_value),
        .o_valid        (o_valid),
        .o_result_value (o_result_value),
        .o_status       (o_status),
        .o_last         (o_last)
    );

    sorted_list_checker u_checker (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_opcode       (i_opcode),
        .i_value        (i_value),
        .i_valid        (o_valid),
        .i_result_value (o_result_value),
        .i_status       (o_status),
        .i_last         (o_last),
        .o_fail_count   (fail_count),
        .o_pending      (pending)
    );

    initial i_clk = 1'b0;
    always #6 i_clk = ~i_clk;

    function automatic logic signed [DATA_W-1:0] rand_value();
        case ($urandom_range(0, 3))
            0: begin
                case ($urandom_range(0, 4))
                    0: return VAL_MIN;
                    1: return VAL_MAX;
                    2: return 0;
                    3: return -1;
                    default: return 1;
                endcase
            end
            1: return $signed($urandom_range(0, 16)) - 8;
            default: return $urandom;
        endcase
    endfunction

    function automatic logic signed [DATA_W-1:0] pick_present();
        if (held.size() > 0 && $urandom_range(0, 4) != 0)
            return held[$urandom_range(0, held.size() - 1)];
        return rand_value();
    endfunction

    task automatic send(input logic [1:0] op, input logic signed [DATA_W-1:0] val);
        int gap;
        int idx;
        if ($urandom_range(0, 15) == 0) burst = !burst;
        gap = burst ? 0 : $urandom_range(0, 12);
        repeat (gap) begin
            @(negedge i_clk);
            start    <= 1'b0;
            i_opcode <= 2'($urandom);
            i_value  <= $urandom;
        end
        @(negedge i_clk);
        start    <= 1'b1;
        i_opcode <= op;
        i_value  <= val;
        do @(posedge i_clk); while (busy);
        if (op == OP_INSERT && held.size() < CAPACITY) begin
            held.push_back(val);
        end else if (op == OP_DELETE) begin
            idx = -1;
            foreach (held[k]) if (idx < 0 && held[k] == val) idx = k;
            if (idx >= 0) held.delete(idx);
        end
    endtask

    initial begin
        i_rst_n  = 1'b0;
        start    = 1'b0;
        i_opcode = OP_INSERT;
        i_value  = '0;
        burst    = 1'b0;
        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Reads and a delete on the empty list, then extremes and duplicates.
        send(OP_READ_ASC, $urandom);
        send(OP_READ_DESC, $urandom);
        send(OP_DELETE, 7);
        send(OP_INSERT, 0);
        send(OP_INSERT, VAL_MAX);
        send(OP_INSERT, VAL_MIN);
        send(OP_INSERT, -1);
        send(OP_INSERT, 1);
        send(OP_INSERT, 0);
        send(OP_INSERT, VAL_MAX);
        send(OP_READ_ASC, $urandom);
        send(OP_READ_DESC, $urandom);
        send(OP_DELETE, 0);
        send(OP_DELETE, 2);
        send(OP_DELETE, VAL_MIN);
        send(OP_DELETE, VAL_MAX);
        send(OP_READ_ASC, $urandom);
        send(OP_READ_DESC, $urandom);
        send(OP_DELETE, VAL_MIN);

        // Fill past capacity so that some inserts are refused.
        repeat (36) send(OP_INSERT, rand_value());
        send(OP_READ_ASC, $urandom);
        send(OP_READ_DESC, $urandom);

        repeat (36) begin
            case ($urandom_range(0, 9))
                0, 1, 2, 3: send(OP_INSERT, rand_value());
                4, 5, 6:    send(OP_DELETE, pick_present());
                7:          send(OP_READ_ASC, $urandom);
                8:          send(OP_READ_DESC, $urandom);
                default:    send(OP_DELETE, rand_value());
            endcase
        end

        while (held.size() > 0) send(OP_DELETE, held[$urandom_range(0, held.size() - 1)]);
        send(OP_READ_ASC, $urandom);
        send(OP_READ_DESC, $urandom);
        send(OP_DELETE, rand_value());

        @(negedge i_clk);
        start <= 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (40) @(negedge i_clk);
        if (fail_count == 0 && pending == 0) begin
            $display("sorted_list_engine_unit: match");
        end else begin
            $display("sorted_list_engine_unit: mismatch");
        end
        $finish;
    end

    initial begin
        #3000000;
        $display("sorted_list_engine_unit: mismatch");
        $finish;
    end

endmodule
